// ===== src/ccpe_pkg.sv =====
// ----------------------------------------------------------------------------
// ccpe_pkg
// Shared constants and types of the cubic curve point evaluator.
// ----------------------------------------------------------------------------
package ccpe_pkg;

  // default geometry of the ports
  localparam int COORD_WIDTH_DEF     = 16;
  localparam int PARAM_FRAC_BITS_DEF = 16;

  // extra fraction bits kept in the horner accumulator
  localparam int GUARD_BITS = 8;

  // load enables of the two register stages of one horner step
  typedef struct packed {
    logic mul_en;
    logic add_en;
  } step_ctrl_t;

endpackage

// ===== src/ccpe_coef_stage.sv =====
// ----------------------------------------------------------------------------
// ccpe_coef_stage
// First pipeline stage: clamps the curve parameter and forms the power-form
// coefficients of all three components for either curve kind.
// ----------------------------------------------------------------------------
module ccpe_coef_stage
  import ccpe_pkg::*;
#(
  parameter int COORD_WIDTH     = COORD_WIDTH_DEF,
  parameter int PARAM_FRAC_BITS = PARAM_FRAC_BITS_DEF
) (
  input  logic                                       clk,
  input  logic                                       en,
  input  logic                                       mode,
  input  logic [3*COORD_WIDTH-1:0]                   point_zero,
  input  logic [3*COORD_WIDTH-1:0]                   point_one,
  input  logic [3*COORD_WIDTH-1:0]                   point_two,
  input  logic [3*COORD_WIDTH-1:0]                   point_three,
  input  logic [PARAM_FRAC_BITS:0]                   param_t,
  output logic                                       mode_q,
  output logic [PARAM_FRAC_BITS:0]                   t_q,
  output logic signed [COORD_WIDTH+3:0]              coef_q [3][3],
  output logic signed [COORD_WIDTH+GUARD_BITS+5:0]   acc_q [3]
);

  localparam int W  = COORD_WIDTH;
  localparam int CW = COORD_WIDTH + 4;
  localparam int AW = COORD_WIDTH + GUARD_BITS + 6;
  localparam int TW = PARAM_FRAC_BITS + 1;
  localparam logic [TW-1:0] T_ONE = TW'(1) << PARAM_FRAC_BITS;

  logic signed [CW-1:0] p0 [3];
  logic signed [CW-1:0] p1 [3];
  logic signed [CW-1:0] p2 [3];
  logic signed [CW-1:0] p3 [3];
  logic signed [CW-1:0] c0_next [3];
  logic signed [CW-1:0] c1_next [3];
  logic signed [CW-1:0] c2_next [3];
  logic signed [CW-1:0] c3_next [3];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      p0[l] = CW'($signed(point_zero[l*W +: W]));
      p1[l] = CW'($signed(point_one[l*W +: W]));
      p2[l] = CW'($signed(point_two[l*W +: W]));
      p3[l] = CW'($signed(point_three[l*W +: W]));
      c3_next[l] = p3[l] - p0[l] + (p1[l] <<< 1) + p1[l] - (p2[l] <<< 1) - p2[l];
      if (mode) begin
        // bezier
        c0_next[l] = p0[l];
        c1_next[l] = (p1[l] <<< 1) + p1[l] - (p0[l] <<< 1) - p0[l];
        c2_next[l] = (p0[l] <<< 1) + p0[l] - (p1[l] <<< 2) - (p1[l] <<< 1)
                     + (p2[l] <<< 1) + p2[l];
      end else begin
        // catmull-rom, doubled; halved at the end
        c0_next[l] = p1[l] <<< 1;
        c1_next[l] = p2[l] - p0[l];
        c2_next[l] = (p0[l] <<< 1) - (p1[l] <<< 2) - p1[l] + (p2[l] <<< 2) - p3[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mode_q <= mode;
      t_q    <= (param_t > T_ONE) ? T_ONE : param_t;
      for (int l = 0; l < 3; l++) begin
        coef_q[l][0] <= c0_next[l];
        coef_q[l][1] <= c1_next[l];
        coef_q[l][2] <= c2_next[l];
        acc_q[l]     <= (AW'(c3_next[l])) <<< GUARD_BITS;
      end
    end
  end

endmodule

// ===== src/ccpe_horner_step.sv =====
// ----------------------------------------------------------------------------
// ccpe_horner_step
// One horner step of one component: a multiply stage (acc * t) followed by
// a stage that rounds the product back to accumulator scale and adds the
// next coefficient.
// ----------------------------------------------------------------------------
module ccpe_horner_step
  import ccpe_pkg::*;
#(
  parameter int COORD_WIDTH     = COORD_WIDTH_DEF,
  parameter int PARAM_FRAC_BITS = PARAM_FRAC_BITS_DEF
) (
  input  logic                                      clk,
  input  step_ctrl_t                                ctrl,
  input  logic signed [COORD_WIDTH+GUARD_BITS+5:0]  acc_in,
  input  logic [PARAM_FRAC_BITS:0]                  t_in,
  input  logic signed [COORD_WIDTH+3:0]             c_in,
  output logic signed [COORD_WIDTH+GUARD_BITS+5:0]  acc_out
);

  localparam int CW = COORD_WIDTH + 4;
  localparam int AW = COORD_WIDTH + GUARD_BITS + 6;
  localparam int TW = PARAM_FRAC_BITS + 1;
  localparam int PW = AW + TW + 1;
  localparam logic signed [PW-1:0] HALF = PW'(1) <<< (PARAM_FRAC_BITS - 1);

  logic signed [TW:0]    t_s;
  logic signed [PW-1:0]  prod;
  logic signed [PW-1:0]  prod_rnd;
  logic signed [AW-1:0]  c_shift;

  assign t_s      = $signed({1'b0, t_in});
  // round half up, then drop the parameter fraction bits
  assign prod_rnd = (prod + HALF) >>> PARAM_FRAC_BITS;
  assign c_shift  = (AW'(c_in)) <<< GUARD_BITS;

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= acc_in * t_s;
    end
    if (ctrl.add_en) begin
      acc_out <= $signed(prod_rnd[AW-1:0]) + c_shift;
    end
  end

endmodule

// ===== src/cubic_curve_point_evaluator_top.sv =====
// ----------------------------------------------------------------------------
// cubic_curve_point_evaluator_top
// Evaluates one point on a Catmull-Rom segment or a cubic Bezier curve.
//
// Input channel: mode, the four control points and param_t move on a
// transfer of in_valid with in_stall low. Output channel: curve_point and
// clipped move on a transfer of out_valid with out_stall low.
// The pipeline has eight register stages: coefficients, three horner steps
// of multiply then round-and-add, and the final rounding with saturation.
// One item is taken every cycle while in_stall is low; the three
// dependent multiplies of the horner chain each have their own stage, so
// the rate is one per cycle.
// Each stage carries its own valid bit and loads whenever it is empty or
// its successor loads, so a stalled receiver only squeezes out bubbles;
// in_stall is high only while all eight stages hold an item and out_stall
// is high.
// Reset empties the pipeline; no result is lost or repeated by a stall.
// param_t above 1.0 counts as 1.0; clipped flags a saturated component.
// ----------------------------------------------------------------------------
module cubic_curve_point_evaluator_top
  import ccpe_pkg::*;
#(
  parameter int COORD_WIDTH     = COORD_WIDTH_DEF,
  parameter int PARAM_FRAC_BITS = PARAM_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          mode,
  input  logic [3*COORD_WIDTH-1:0]      point_zero,
  input  logic [3*COORD_WIDTH-1:0]      point_one,
  input  logic [3*COORD_WIDTH-1:0]      point_two,
  input  logic [3*COORD_WIDTH-1:0]      point_three,
  input  logic [PARAM_FRAC_BITS:0]      param_t,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [3*COORD_WIDTH-1:0]      curve_point,
  output logic                          clipped
);

  localparam int W      = COORD_WIDTH;
  localparam int CW     = COORD_WIDTH + 4;
  localparam int AW     = COORD_WIDTH + GUARD_BITS + 6;
  localparam int TW     = PARAM_FRAC_BITS + 1;
  localparam int STAGES = 8;
  localparam logic [TW-1:0]        T_ONE   = TW'(1) << PARAM_FRAC_BITS;
  localparam logic signed [AW-1:0] HALF_B  = AW'(1) <<< (GUARD_BITS - 1);
  localparam logic signed [AW-1:0] HALF_C  = AW'(1) <<< GUARD_BITS;
  localparam logic signed [AW-1:0] HI      = AW'((2 ** (W - 1)) - 1);
  localparam logic signed [AW-1:0] LO      = -HI - AW'(1);
  localparam logic [W-1:0]         HI_W    = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]         LO_W    = {1'b1, {(W-1){1'b0}}};

  logic [STAGES-1:0] v;
  logic [STAGES:0]   ready;
  logic [STAGES-1:0] vin;
  logic [STAGES-1:0] en;

  // stage 0 outputs
  logic                  mode_s0;
  logic [TW-1:0]         t_s0;
  logic signed [CW-1:0]  coef_s0 [3][3];
  logic signed [AW-1:0]  acc_s0 [3];

  // side data that travels with the horner stages
  logic                  mode_p [1:6];
  logic [TW-1:0]         t_p [1:4];
  logic signed [CW-1:0]  coef_p [1:5][3][3];

  logic signed [AW-1:0]  acc_h [3][3];
  step_ctrl_t            ctrl [3];

  logic signed [AW-1:0]  rnd [3];
  logic [3*W-1:0]        point_next;
  logic                  clip_next;

  // a stage loads when it is empty or its successor loads
  always_comb begin
    ready[STAGES] = !out_stall;
    for (int k = STAGES - 1; k >= 0; k--) begin
      ready[k] = !v[k] || ready[k+1];
    end
  end

  assign vin       = {v[STAGES-2:0], in_valid};
  assign en        = ready[STAGES-1:0] & vin;
  assign in_stall  = !ready[0];
  assign out_valid = v[STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 0; k < STAGES; k++) begin
        if (ready[k]) begin
          v[k] <= vin[k];
        end
      end
    end
  end

  ccpe_coef_stage #(
    .COORD_WIDTH     (COORD_WIDTH),
    .PARAM_FRAC_BITS (PARAM_FRAC_BITS)
  ) u_coef (
    .clk         (clk),
    .en          (en[0]),
    .mode        (mode),
    .point_zero  (point_zero),
    .point_one   (point_one),
    .point_two   (point_two),
    .point_three (point_three),
    .param_t     (param_t),
    .mode_q      (mode_s0),
    .t_q         (t_s0),
    .coef_q      (coef_s0),
    .acc_q       (acc_s0)
  );

  always_ff @(posedge clk) begin
    if (en[1]) begin
      mode_p[1] <= mode_s0;
      t_p[1]    <= t_s0;
      coef_p[1] <= coef_s0;
    end
    for (int k = 2; k <= 6; k++) begin
      if (en[k]) begin
        mode_p[k] <= mode_p[k-1];
      end
    end
    for (int k = 2; k <= 4; k++) begin
      if (en[k]) begin
        t_p[k] <= t_p[k-1];
      end
    end
    for (int k = 2; k <= 5; k++) begin
      if (en[k]) begin
        coef_p[k] <= coef_p[k-1];
      end
    end
  end

  for (genvar j = 0; j < 3; j++) begin : g_step
    assign ctrl[j] = '{mul_en: en[2*j+1], add_en: en[2*j+2]};
    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic signed [AW-1:0] acc_in;
      logic [TW-1:0]        t_in;
      if (j == 0) begin : g_first
        assign acc_in = acc_s0[l];
        assign t_in   = t_s0;
      end else begin : g_next
        assign acc_in = acc_h[j-1][l];
        assign t_in   = t_p[2*j];
      end
      // step j adds c2, c1, c0 in turn
      ccpe_horner_step #(
        .COORD_WIDTH     (COORD_WIDTH),
        .PARAM_FRAC_BITS (PARAM_FRAC_BITS)
      ) u_step (
        .clk     (clk),
        .ctrl    (ctrl[j]),
        .acc_in  (acc_in),
        .t_in    (t_in),
        .c_in    (coef_p[2*j+1][l][2-j]),
        .acc_out (acc_h[j][l])
      );
    end
  end

  // drop guard bits (and the catmull-rom factor of two), then saturate
  always_comb begin
    clip_next = 1'b0;
    for (int l = 0; l < 3; l++) begin
      if (mode_p[6]) begin
        rnd[l] = (acc_h[2][l] + HALF_B) >>> GUARD_BITS;
      end else begin
        rnd[l] = (acc_h[2][l] + HALF_C) >>> (GUARD_BITS + 1);
      end
      if (rnd[l] > HI) begin
        point_next[l*W +: W] = HI_W;
        clip_next = 1'b1;
      end else if (rnd[l] < LO) begin
        point_next[l*W +: W] = LO_W;
        clip_next = 1'b1;
      end else begin
        point_next[l*W +: W] = rnd[l][W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[STAGES-1]) begin
      curve_point <= point_next;
      clipped     <= clip_next;
    end
  end

`ifndef SYNTHESIS
  // input is held off only when every stage holds an item
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (&v))
    else $error("in_stall raised with an empty pipeline stage");

  // the parameter is clamped to one on entry
  a_t_clamped: assert property (@(posedge clk) disable iff (rst)
    v[0] |-> (t_s0 <= T_ONE))
    else $error("clamped parameter above one");

  // a blocked item in the last horner stage keeps the accumulators of components 0 and 2
  a_hold_acc: assert property (@(posedge clk) disable iff (rst)
    (v[6] && !ready[6]) |=> (v[6] && $stable(acc_h[2][0]) && $stable(acc_h[2][2])))
    else $error("stalled accumulator changed");

  // a clipped result has a component at a range limit
  a_clip_limit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && clipped) |->
      (curve_point[W-1:0] == HI_W || curve_point[W-1:0] == LO_W ||
       curve_point[2*W-1:W] == HI_W || curve_point[2*W-1:W] == LO_W ||
       curve_point[3*W-1:2*W] == HI_W || curve_point[3*W-1:2*W] == LO_W))
    else $error("clipped set with no component at a limit");
`endif

endmodule
